// ----- rtl/stok_pkg.sv -----
// ----------------------------------------------------------------------------
// stok_pkg
// Types, token kinds, error codes and lookup functions for the tokenizer.
// ----------------------------------------------------------------------------
`default_nettype none

package stok_pkg;

   // token kinds
   localparam logic [5:0] KIND_IDENT  = 6'd0;
   localparam logic [5:0] KIND_INT    = 6'd1;
   localparam logic [5:0] KIND_STR    = 6'd2;
   localparam logic [5:0] KIND_KW0    = 6'd3;
   localparam logic [5:0] KIND_DIV    = 6'd20;
   localparam logic [5:0] KIND_EQEQ   = 6'd31;
   localparam logic [5:0] KIND_ASSIGN = 6'd32;
   localparam logic [5:0] KIND_NE     = 6'd33;
   localparam logic [5:0] KIND_NOT    = 6'd34;
   localparam logic [5:0] KIND_LE     = 6'd35;
   localparam logic [5:0] KIND_LT     = 6'd36;
   localparam logic [5:0] KIND_GE     = 6'd37;
   localparam logic [5:0] KIND_GT     = 6'd38;
   localparam logic [5:0] KIND_ANDAND = 6'd39;
   localparam logic [5:0] KIND_OROR   = 6'd40;
   localparam logic [5:0] KIND_ERR    = 6'd41;
   localparam logic [5:0] KIND_END    = 6'd42;

   // error codes
   localparam logic [2:0] ERR_NONE     = 3'd0;
   localparam logic [2:0] ERR_UNTERM   = 3'd1;
   localparam logic [2:0] ERR_ESC_END  = 3'd2;
   localparam logic [2:0] ERR_BAD_ESC  = 3'd3;
   localparam logic [2:0] ERR_LONE_AMP = 3'd4;
   localparam logic [2:0] ERR_LONE_BAR = 3'd5;
   localparam logic [2:0] ERR_BAD_CHAR = 3'd6;

   localparam int          NUM_KW   = 14;
   localparam logic [15:0] LEN_MAX  = 16'hFFFF;

   // keyword text, first character in the lowest byte
   localparam logic [47:0] KW_TEXT [NUM_KW] = '{
      48'("fi"), 48'("esle"), 48'("elihw"), 48'("kaerb"), 48'("nruter"),
      48'("tcurts"), 48'("wen"), 48'("llun"), 48'("tni"), 48'("loob"),
      48'("gnirts"), 48'("diov"), 48'("eurt"), 48'("eslaf")
   };
   localparam logic [2:0] KW_LEN [NUM_KW] = '{
      3'd2, 3'd4, 3'd5, 3'd5, 3'd6, 3'd6, 3'd3, 3'd4, 3'd3, 3'd4, 3'd6, 3'd4,
      3'd4, 3'd5
   };

   // one result record
   typedef struct packed {
      logic        is_content;
      logic [5:0]  kind;
      logic [2:0]  error_code;
      logic [15:0] start_line;
      logic [15:0] start_col;
      logic [15:0] token_length;
      logic [7:0]  data_byte;
   } result_type;

   // keyword lookup over the first six buffered bytes
   function automatic logic [5:0] kw_kind(input logic [47:0] text, input logic [2:0] len);
      logic [5:0] k;
      logic       hit;
      k = KIND_IDENT;
      for (int i = NUM_KW - 1; i >= 0; i--) begin
         hit = (KW_LEN[i] == len);
         for (int j = 0; j < 6; j++) begin
            if (3'(j) < len && text[8*j +: 8] != KW_TEXT[i][8*j +: 8]) hit = 1'b0;
         end
         if (hit) k = KIND_KW0 + 6'(i);
      end
      return k;
   endfunction

   // single-character operators, error kind when none
   function automatic logic [5:0] single_kind(input logic [7:0] b);
      logic [5:0] k;
      unique case (b)
         "+":     k = 6'd17;
         "-":     k = 6'd18;
         "*":     k = 6'd19;
         "/":     k = KIND_DIV;
         "%":     k = 6'd21;
         "(":     k = 6'd22;
         ")":     k = 6'd23;
         "{":     k = 6'd24;
         "}":     k = 6'd25;
         "[":     k = 6'd26;
         "]":     k = 6'd27;
         ",":     k = 6'd28;
         ";":     k = 6'd29;
         ".":     k = 6'd30;
         default: k = KIND_ERR;
      endcase
      return k;
   endfunction

   // kind of a pending comparison or logic operator
   function automatic logic [5:0] op2_kind(input logic [7:0] p, input logic two);
      logic [5:0] k;
      unique case (p)
         "=":     k = two ? KIND_EQEQ : KIND_ASSIGN;
         "!":     k = two ? KIND_NE : KIND_NOT;
         "<":     k = two ? KIND_LE : KIND_LT;
         ">":     k = two ? KIND_GE : KIND_GT;
         "&":     k = two ? KIND_ANDAND : KIND_ERR;
         default: k = two ? KIND_OROR : KIND_ERR;
      endcase
      return k;
   endfunction

   function automatic logic [2:0] op2_err(input logic [7:0] p);
      logic [2:0] e;
      unique case (p)
         "&":     e = ERR_LONE_AMP;
         "|":     e = ERR_LONE_BAR;
         default: e = ERR_NONE;
      endcase
      return e;
   endfunction

endpackage

`default_nettype wire

// ----- rtl/stok_scan.sv -----
// ----------------------------------------------------------------------------
// stok_scan
// Scanner state and the single-pass next-state and result logic.
// ----------------------------------------------------------------------------
`default_nettype none

module stok_scan #(
   parameter int KEYWORD_MAX_LEN = 6,
   parameter int POSITION_BITS   = 16
) (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   step,
   input  wire                   end_of_input,
   input  wire [7:0]             in_byte,
   output logic                  res0_valid,
   output logic                  res1_valid,
   output stok_pkg::result_type  res0,
   output stok_pkg::result_type  res1
);

   localparam logic [3:0] M_IDLE  = 4'd0;
   localparam logic [3:0] M_SLASH = 4'd1;
   localparam logic [3:0] M_LINE  = 4'd2;
   localparam logic [3:0] M_BLOCK = 4'd3;
   localparam logic [3:0] M_BSTAR = 4'd4;
   localparam logic [3:0] M_IDENT = 4'd5;
   localparam logic [3:0] M_NUM   = 4'd6;
   localparam logic [3:0] M_OP2   = 4'd7;
   localparam logic [3:0] M_STR   = 4'd8;
   localparam logic [3:0] M_ESC   = 4'd9;

   localparam logic [POSITION_BITS-1:0] POS_MAX = '1;
   localparam logic [POSITION_BITS-1:0] POS_ONE = POSITION_BITS'(1);

   logic [3:0]                         mode_ff, mode_in;
   logic [7:0]                         pend_ff, pend_in;
   logic [POSITION_BITS-1:0]           tline_ff, tline_in, tcol_ff, tcol_in;
   logic [POSITION_BITS-1:0]           cline_ff, cline_in, ccol_ff, ccol_in;
   logic [15:0]                        tlen_ff, tlen_in;
   logic [KEYWORD_MAX_LEN-1:0][7:0]    kbuf_ff, kbuf_in;

   stok_pkg::result_type e0, e1;
   logic                 v0, v1, redo;
   logic [15:0]          tlen_inc, tl16, tc16, cl16, cc16;
   logic [31:0]          tl_w, tc_w, cl_w, cc_w;
   logic [5:0]           word_kind, sk;
   logic                 is_letter, is_num, is_ws;

   // positions shown in 16 bits
   assign tl_w = 32'(tline_ff);
   assign tc_w = 32'(tcol_ff);
   assign cl_w = 32'(cline_ff);
   assign cc_w = 32'(ccol_ff);
   assign tl16 = tl_w[15:0];
   assign tc16 = tc_w[15:0];
   assign cl16 = cl_w[15:0];
   assign cc16 = cc_w[15:0];

   assign tlen_inc  = (tlen_ff == stok_pkg::LEN_MAX) ? tlen_ff : tlen_ff + 16'd1;
   assign is_letter = (in_byte >= "a" && in_byte <= "z") || (in_byte >= "A" && in_byte <= "Z")
                      || in_byte == "_";
   assign is_num    = in_byte >= "0" && in_byte <= "9";
   assign is_ws     = in_byte == " " || in_byte == 8'h09 || in_byte == 8'h0D
                      || in_byte == 8'h0A;
   assign sk        = stok_pkg::single_kind(in_byte);

   // identifier or keyword
   always_comb begin
      if (tlen_ff > 16'(KEYWORD_MAX_LEN)) begin
         word_kind = stok_pkg::KIND_IDENT;
      end else begin
         word_kind = stok_pkg::kw_kind(kbuf_ff[5:0], tlen_ff[2:0]);
      end
   end

   // next state and results for one transaction
   always_comb begin
      mode_in  = mode_ff;
      pend_in  = pend_ff;
      tline_in = tline_ff;
      tcol_in  = tcol_ff;
      tlen_in  = tlen_ff;
      cline_in = cline_ff;
      ccol_in  = ccol_ff;
      kbuf_in  = kbuf_ff;
      redo     = 1'b0;
      v0       = 1'b0;
      v1       = 1'b0;
      e0       = '{is_content: 1'b0, kind: stok_pkg::KIND_ERR,
                   error_code: stok_pkg::ERR_NONE, start_line: tl16, start_col: tc16,
                   token_length: tlen_ff, data_byte: 8'd0};
      e1       = e0;
      if (end_of_input) begin
         // flush pending token, then end token
         v0 = 1'b1;
         unique case (mode_ff)
            M_SLASH: e0.kind = stok_pkg::KIND_DIV;
            M_IDENT: e0.kind = word_kind;
            M_NUM:   e0.kind = stok_pkg::KIND_INT;
            M_OP2: begin
               e0.kind       = stok_pkg::op2_kind(pend_ff, 1'b0);
               e0.error_code = stok_pkg::op2_err(pend_ff);
            end
            M_STR:   e0.error_code = stok_pkg::ERR_UNTERM;
            M_ESC:   e0.error_code = stok_pkg::ERR_ESC_END;
            default: v0 = 1'b0;
         endcase
         v1 = 1'b1;
         e1 = '{is_content: 1'b0, kind: stok_pkg::KIND_END,
                error_code: stok_pkg::ERR_NONE, start_line: cl16, start_col: cc16,
                token_length: 16'd0, data_byte: 8'd0};
         mode_in  = M_IDLE;
         pend_in  = 8'd0;
         tline_in = POS_ONE;
         tcol_in  = POS_ONE;
         tlen_in  = 16'd0;
         cline_in = POS_ONE;
         ccol_in  = POS_ONE;
      end else begin
         // continue the token in progress
         unique case (mode_ff)
            M_SLASH: begin
               if (in_byte == "/") mode_in = M_LINE;
               else if (in_byte == "*") mode_in = M_BLOCK;
               else begin
                  v0      = 1'b1;
                  e0.kind = stok_pkg::KIND_DIV;
                  redo    = 1'b1;
               end
            end
            M_LINE:  if (in_byte == 8'h0A) mode_in = M_IDLE;
            M_BLOCK: if (in_byte == "*") mode_in = M_BSTAR;
            M_BSTAR: begin
               if (in_byte == "/") mode_in = M_IDLE;
               else if (in_byte != "*") mode_in = M_BLOCK;
            end
            M_IDENT: begin
               if (is_letter || is_num) begin
                  for (int i = 0; i < KEYWORD_MAX_LEN; i++) begin
                     if (tlen_ff == 16'(i)) kbuf_in[i] = in_byte;
                  end
                  tlen_in = tlen_inc;
               end else begin
                  v0      = 1'b1;
                  e0.kind = word_kind;
                  redo    = 1'b1;
               end
            end
            M_NUM: begin
               if (is_num) tlen_in = tlen_inc;
               else begin
                  v0      = 1'b1;
                  e0.kind = stok_pkg::KIND_INT;
                  redo    = 1'b1;
               end
            end
            M_OP2: begin
               v0 = 1'b1;
               if ((in_byte == "=" && pend_ff != "&" && pend_ff != "|")
                   || ((pend_ff == "&" || pend_ff == "|") && in_byte == pend_ff)) begin
                  tlen_in         = tlen_inc;
                  e0.token_length = tlen_inc;
                  e0.kind         = stok_pkg::op2_kind(pend_ff, 1'b1);
                  mode_in         = M_IDLE;
               end else begin
                  e0.kind       = stok_pkg::op2_kind(pend_ff, 1'b0);
                  e0.error_code = stok_pkg::op2_err(pend_ff);
                  redo          = 1'b1;
               end
            end
            M_STR: begin
               v0 = 1'b1;
               if (in_byte == "\"") begin
                  tlen_in         = tlen_inc;
                  e0.token_length = tlen_inc;
                  e0.kind         = stok_pkg::KIND_STR;
                  mode_in         = M_IDLE;
               end else if (in_byte == 8'h0A) begin
                  e0.error_code = stok_pkg::ERR_UNTERM;
                  redo          = 1'b1;
               end else if (in_byte == "\\") begin
                  v0      = 1'b0;
                  tlen_in = tlen_inc;
                  mode_in = M_ESC;
               end else begin
                  tlen_in         = tlen_inc;
                  e0.is_content   = 1'b1;
                  e0.kind         = stok_pkg::KIND_STR;
                  e0.token_length = 16'd0;
                  e0.data_byte    = in_byte;
               end
            end
            M_ESC: begin
               v0      = 1'b1;
               tlen_in = tlen_inc;
               if (in_byte == "n" || in_byte == "t" || in_byte == "\\" || in_byte == "\"") begin
                  e0.is_content   = 1'b1;
                  e0.kind         = stok_pkg::KIND_STR;
                  e0.token_length = 16'd0;
                  e0.data_byte    = (in_byte == "n") ? 8'h0A :
                                    (in_byte == "t") ? 8'h09 : in_byte;
                  mode_in         = M_STR;
               end else begin
                  e0.token_length = tlen_inc;
                  e0.error_code   = stok_pkg::ERR_BAD_ESC;
                  e0.data_byte    = in_byte;
                  mode_in         = M_IDLE;
               end
            end
            default: redo = 1'b1;
         endcase

         // start a new token from this byte
         if (redo) begin
            mode_in = M_IDLE;
            if (!is_ws) begin
               tline_in = cline_ff;
               tcol_in  = ccol_ff;
               tlen_in  = 16'd1;
               e1 = '{is_content: 1'b0, kind: sk, error_code: stok_pkg::ERR_NONE,
                      start_line: cl16, start_col: cc16, token_length: 16'd1,
                      data_byte: 8'd0};
               priority if (in_byte == "/") mode_in = M_SLASH;
               else if (is_letter) begin
                  kbuf_in[0] = in_byte;
                  mode_in    = M_IDENT;
               end
               else if (is_num) mode_in = M_NUM;
               else if (in_byte == "\"") mode_in = M_STR;
               else if (in_byte == "=" || in_byte == "!" || in_byte == "<" || in_byte == ">"
                        || in_byte == "&" || in_byte == "|") begin
                  pend_in = in_byte;
                  mode_in = M_OP2;
               end
               else begin
                  v1 = 1'b1;
                  if (sk == stok_pkg::KIND_ERR) begin
                     e1.error_code = stok_pkg::ERR_BAD_CHAR;
                     e1.data_byte  = in_byte;
                  end
               end
            end
         end

         // source position
         if (in_byte == 8'h0A) begin
            if (cline_ff != POS_MAX) cline_in = cline_ff + POS_ONE;
            ccol_in = POS_ONE;
         end else if (ccol_ff != POS_MAX) begin
            ccol_in = ccol_ff + POS_ONE;
         end
      end
   end

   // compact the two emit slots
   assign res0_valid = v0 || v1;
   assign res1_valid = v0 && v1;
   assign res0       = v0 ? e0 : e1;
   assign res1       = e1;

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= M_IDLE;
         pend_ff  <= 8'd0;
         tline_ff <= POS_ONE;
         tcol_ff  <= POS_ONE;
         tlen_ff  <= 16'd0;
         cline_ff <= POS_ONE;
         ccol_ff  <= POS_ONE;
      end else if (step) begin
         mode_ff  <= mode_in;
         pend_ff  <= pend_in;
         tline_ff <= tline_in;
         tcol_ff  <= tcol_in;
         tlen_ff  <= tlen_in;
         cline_ff <= cline_in;
         ccol_ff  <= ccol_in;
      end
   end

   // keyword buffer, written before read
   always_ff @(posedge clock) begin
      if (step) kbuf_ff <= kbuf_in;
   end

endmodule

`default_nettype wire

// ----- rtl/stok_queue.sv -----
// ----------------------------------------------------------------------------
// stok_queue
// Four-entry result queue taking up to two records per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module stok_queue (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   push0,
   input  wire                   push1,
   input  stok_pkg::result_type  data0,
   input  stok_pkg::result_type  data1,
   output logic                  room2,
   output logic                  out_valid,
   input  wire                   out_ready,
   output stok_pkg::result_type  out_data
);

   stok_pkg::result_type mem_ff [4];
   logic [1:0]           wr_ff, wr_in, rd_ff, rd_in;
   logic [2:0]           cnt_ff, cnt_in;
   logic                 pop;

   assign room2     = cnt_ff <= 3'd2;
   assign out_valid = cnt_ff != 3'd0;
   assign out_data  = mem_ff[rd_ff];
   assign pop       = out_valid && out_ready;

   // pointer and fill arithmetic
   always_comb begin
      wr_in  = wr_ff + 2'(push0) + 2'(push1);
      rd_in  = rd_ff + 2'(pop);
      cnt_in = cnt_ff + 3'(push0) + 3'(push1) - 3'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= 2'd0;
         rd_ff  <= 2'd0;
         cnt_ff <= 3'd0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (push0) mem_ff[wr_ff] <= data0;
      if (push1) mem_ff[wr_ff + 2'd1] <= data1;
   end

endmodule

`default_nettype wire

// ----- rtl/source_tokenizer.sv -----
// ----------------------------------------------------------------------------
// source_tokenizer
// Streaming lexer: source bytes in, token records and string content out.
// ----------------------------------------------------------------------------
// channel  direction  tdata                 tuser
// req_     in         in_byte               op (1 = end of input)
// rsp_     out        error, pos, len, data is_content, kind
//
// Each byte is scanned in the cycle it is accepted and its up to two result
// transactions enter a four-entry queue; a byte can be taken every cycle while
// two slots are free. Bytes that emit two results drain at one per cycle, so the
// queue's free room sets the rate when those follow back to back.
// Synchronous reset returns the scanner to between tokens at line 1 col 1;
// req_tready stays low while reset is high.
// A stall on rsp_ only holds off req_ once the queue is nearly full.
`default_nettype none

module source_tokenizer #(
   parameter int KEYWORD_MAX_LEN = 6,
   parameter int POSITION_BITS   = 16
) (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire  [7:0]  req_tdata,   // in_byte[7:0]
   input  wire         req_tuser,   // op
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [63:0] rsp_tdata,   // error_code[2:0], start_line[18:3], start_col[34:19],
                                    // token_length[50:35], data_byte[58:51], zero above
   output logic [6:0]  rsp_tuser    // is_content[0], kind[6:1]
);

   logic                 step, r0v, r1v, room2;
   stok_pkg::result_type r0, r1, head;

   assign req_tready = room2 && !reset;
   assign step       = req_tvalid && req_tready;

   // scanner
   stok_scan #(
      .KEYWORD_MAX_LEN (KEYWORD_MAX_LEN),
      .POSITION_BITS   (POSITION_BITS)
   ) u_scan (
      .clock        (clock),
      .reset        (reset),
      .step         (step),
      .end_of_input (req_tuser),
      .in_byte      (req_tdata),
      .res0_valid   (r0v),
      .res1_valid   (r1v),
      .res0         (r0),
      .res1         (r1)
   );

   // result queue
   stok_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push0     (step && r0v),
      .push1     (step && r1v),
      .data0     (r0),
      .data1     (r1),
      .room2     (room2),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (head)
   );

   assign rsp_tdata = {5'd0, head.data_byte, head.token_length, head.start_col,
                       head.start_line, head.error_code};
   assign rsp_tuser = {head.kind, head.is_content};

endmodule

`default_nettype wire
